FILE: src/im2col_pkg.sv
`default_nettype none

package im2col_pkg;

    // Image and window limits; register values above these count as the limit
    localparam int MAX_HEIGHT   = 32;
    localparam int MAX_WIDTH    = 32;
    localparam int MAX_CHANNELS = 4;
    localparam int MAX_FILTER   = 8;
    localparam int MAX_STRIDE   = 8;

    localparam int STORE_DEPTH = MAX_CHANNELS * MAX_HEIGHT * MAX_WIDTH;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);

    // Shared iterative divider: 12-bit dividend, 7-bit divisor, one bit per cycle
    localparam int DIV_W     = 12;
    localparam int DEN_W     = 7;
    localparam int DIV_CNT_W = $clog2(DIV_W);

    typedef enum logic [2:0] {
        REG_IN_HEIGHT     = 3'd0,
        REG_IN_WIDTH      = 3'd1,
        REG_CHANNELS      = 3'd2,
        REG_FILTER_HEIGHT = 3'd3,
        REG_FILTER_WIDTH  = 3'd4,
        REG_STRIDE        = 3'd5,
        REG_PADDING       = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DEN_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
        logic [DEN_W-1:0] remainder;
    } div_rsp_t;

endpackage

`default_nettype wire

FILE: src/im2col_div.sv
`default_nettype none

module im2col_div (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire im2col_pkg::div_req_t req,
    output im2col_pkg::div_rsp_t      rsp
);

    logic                                busy_reg;
    logic                                busy_next;
    logic                                done_reg;
    logic                                done_next;
    logic [im2col_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [im2col_pkg::DIV_CNT_W-1:0]    cnt_next;
    logic [im2col_pkg::DIV_W-1:0]        quo_reg;
    logic [im2col_pkg::DIV_W-1:0]        quo_next;
    logic [im2col_pkg::DEN_W-1:0]        rem_reg;
    logic [im2col_pkg::DEN_W-1:0]        rem_next;
    logic [im2col_pkg::DEN_W-1:0]        den_reg;
    logic [im2col_pkg::DEN_W-1:0]        den_next;

    logic [im2col_pkg::DEN_W:0]          shifted;
    logic [im2col_pkg::DEN_W:0]          diff;
    logic                                fits;

    always_comb
    begin
        shifted = {rem_reg, quo_reg[im2col_pkg::DIV_W-1]};
        diff    = shifted - {1'b0, den_reg};
        fits    = (shifted >= {1'b0, den_reg});

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;

        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            quo_next  = req.dividend;
            rem_next  = '0;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            // shift in the next dividend bit, subtract when the divisor fits
            quo_next = {quo_reg[im2col_pkg::DIV_W-2:0], fits};
            rem_next = fits ? diff[im2col_pkg::DEN_W-1:0] : shifted[im2col_pkg::DEN_W-1:0];
            cnt_next = cnt_reg + im2col_pkg::DIV_CNT_W'(1);
            if (cnt_reg == im2col_pkg::DIV_CNT_W'(im2col_pkg::DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

`default_nettype wire

FILE: src/im2col_patch_extractor_unit.sv
// A read item passes the s1 stage and then the output register; loads give no item.
// Throughput: one item (load or read) per cycle while running and the output is not stalled; the image store has one
// write port and one registered read port, so each item costs one store access.
// Setup: after reset and after every configuration write a setup pass
// runs five divisions on the shared bit-serial divider; s_tready stays low during it.
// Reset: registers return to 28, 28, 1, 3, 3, 1, 0; load and read counters clear; store undefined.
`default_nettype none

module im2col_patch_extractor_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [5:0]  cfg_data,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] pixel
    input  wire logic        s_tuser,   // [0] kind
    // output stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [55:0]      m_tdata,   // [31:0] value, [43:32] row_index, [51:44] column_index
    output logic             m_tlast,   // end_of_row
    output logic [2:0]       m_tuser    // [0] is_padding, [1] end_of_matrix, [2] config_error
);

    typedef enum logic [9:0] {
        ST_DIV_OH  = 10'b0000000001,
        ST_DIV_OW  = 10'b0000000010,
        ST_PROD1   = 10'b0000000100,
        ST_PROD2   = 10'b0000001000,
        ST_NORM    = 10'b0000010000,
        ST_DIV_ROW = 10'b0000100000,
        ST_DIV_COL = 10'b0001000000,
        ST_DIV_REM = 10'b0010000000,
        ST_PROD3   = 10'b0100000000,
        ST_RUN     = 10'b1000000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   launch_reg;
    logic   launch_next;

    // configuration registers
    logic [5:0] in_height_reg, in_height_next;
    logic [5:0] in_width_reg, in_width_next;
    logic [2:0] channels_reg, channels_next;
    logic [3:0] filter_height_reg, filter_height_next;
    logic [3:0] filter_width_reg, filter_width_next;
    logic [3:0] stride_reg, stride_next;
    logic [2:0] padding_reg, padding_next;

    // clamped geometry
    logic [5:0] h;
    logic [5:0] w;
    logic [2:0] ch;
    logic [3:0] fh;
    logic [3:0] fw;
    logic [3:0] st;
    logic [2:0] pad;
    logic [6:0] span_h;
    logic [6:0] span_w;
    logic [6:0] extent_h;
    logic [6:0] extent_w;
    logic       err_now;

    // setup results
    logic [5:0]  out_h_reg, out_h_next;
    logic [5:0]  out_w_reg, out_w_next;
    logic [11:0] rows_reg, rows_next;
    logic [10:0] hw_reg, hw_next;
    logic [6:0]  fhw_reg, fhw_next;
    logic [8:0]  cols_reg, cols_next;
    logic [12:0] size_reg, size_next;
    logic        err_reg, err_next;
    logic [5:0]  col_rem_reg, col_rem_next;

    // counters
    logic [im2col_pkg::ADDR_W-1:0] load_pos_reg, load_pos_next;
    logic [11:0] read_row_reg, read_row_next;
    logic [7:0]  read_col_reg, read_col_next;
    logic [5:0]  oh_reg, oh_next;
    logic [5:0]  ow_reg, ow_next;
    logic [1:0]  c_reg, c_next;
    logic [2:0]  fy_reg, fy_next;
    logic [2:0]  fx_reg, fx_next;
    logic [8:0]  oh_st_reg, oh_st_next;
    logic [8:0]  ow_st_reg, ow_st_next;
    logic [11:0] c_base_reg, c_base_next;

    // divider
    im2col_pkg::div_req_t div_req;
    im2col_pkg::div_rsp_t div_rsp;
    logic                 div_go;

    // handshake and pipeline
    logic out_free;
    logic pipe_free;
    logic in_acc;
    logic rd_req;
    logic ld_req;

    logic s1_valid_reg, s1_valid_next;
    logic [11:0] s1_row_reg;
    logic [7:0]  s1_col_reg;
    logic        s1_pad_reg;
    logic        s1_eor_reg;
    logic        s1_eom_reg;
    logic        s1_err_reg;
    logic [31:0] rd_data_reg;

    logic out_valid_reg, out_valid_next;
    logic [31:0] out_value_reg;
    logic [11:0] out_row_reg;
    logic [7:0]  out_col_reg;
    logic        out_pad_reg;
    logic        out_eor_reg;
    logic        out_eom_reg;
    logic        out_err_reg;

    // address generation
    logic [9:0]  ypos;
    logic [9:0]  xpos;
    logic [9:0]  y_off;
    logic [9:0]  x_off;
    logic        in_image;
    logic [10:0] row_term;
    logic [12:0] addr_sum;
    logic [im2col_pkg::ADDR_W-1:0] rd_addr;
    logic        last_fx;
    logic        last_fy;
    logic        last_col;
    logic        last_row;
    logic        last_ow;

    logic [31:0] store_mem [im2col_pkg::STORE_DEPTH];

    im2col_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign cfg_ready = 1'b1;

    // ------------------------------------------------------------------
    // configuration decode
    always_comb
    begin
        in_height_next     = in_height_reg;
        in_width_next      = in_width_reg;
        channels_next      = channels_reg;
        filter_height_next = filter_height_reg;
        filter_width_next  = filter_width_reg;
        stride_next        = stride_reg;
        padding_next       = padding_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                im2col_pkg::REG_IN_HEIGHT:     in_height_next     = cfg_data;
                im2col_pkg::REG_IN_WIDTH:      in_width_next      = cfg_data;
                im2col_pkg::REG_CHANNELS:      channels_next      = cfg_data[2:0];
                im2col_pkg::REG_FILTER_HEIGHT: filter_height_next = cfg_data[3:0];
                im2col_pkg::REG_FILTER_WIDTH:  filter_width_next  = cfg_data[3:0];
                im2col_pkg::REG_STRIDE:        stride_next        = cfg_data[3:0];
                im2col_pkg::REG_PADDING:       padding_next       = cfg_data[2:0];
                default:                       ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // clamped geometry
    always_comb
    begin
        h = (in_height_reg == '0) ? 6'd1 :
            (in_height_reg > 6'(im2col_pkg::MAX_HEIGHT)) ? 6'(im2col_pkg::MAX_HEIGHT) :
            in_height_reg;
        w = (in_width_reg == '0) ? 6'd1 :
            (in_width_reg > 6'(im2col_pkg::MAX_WIDTH)) ? 6'(im2col_pkg::MAX_WIDTH) :
            in_width_reg;
        ch = (channels_reg == '0) ? 3'd1 :
             (channels_reg > 3'(im2col_pkg::MAX_CHANNELS)) ? 3'(im2col_pkg::MAX_CHANNELS) :
             channels_reg;
        fh = (filter_height_reg == '0) ? 4'd1 :
             (filter_height_reg > 4'(im2col_pkg::MAX_FILTER)) ? 4'(im2col_pkg::MAX_FILTER) :
             filter_height_reg;
        fw = (filter_width_reg == '0) ? 4'd1 :
             (filter_width_reg > 4'(im2col_pkg::MAX_FILTER)) ? 4'(im2col_pkg::MAX_FILTER) :
             filter_width_reg;
        st = (stride_reg == '0) ? 4'd1 :
             (stride_reg > 4'(im2col_pkg::MAX_STRIDE)) ? 4'(im2col_pkg::MAX_STRIDE) :
             stride_reg;
        pad = padding_reg;

        span_h   = {1'b0, h} + {3'b000, pad, 1'b0};
        span_w   = {1'b0, w} + {3'b000, pad, 1'b0};
        extent_h = span_h - {3'b000, fh};
        extent_w = span_w - {3'b000, fw};
        err_now  = ({3'b000, fh} > span_h) || ({3'b000, fw} > span_w);
    end

    // ------------------------------------------------------------------
    // handshake
    assign out_free  = !out_valid_reg || m_tready;
    assign pipe_free = !s1_valid_reg || out_free;
    assign s_tready  = (state_reg == ST_RUN) && pipe_free;
    assign in_acc    = s_tvalid && s_tready;
    assign rd_req    = in_acc && s_tuser;
    assign ld_req    = in_acc && !s_tuser;

    // ------------------------------------------------------------------
    // address of the current element
    always_comb
    begin
        ypos     = {1'b0, oh_st_reg} + {7'd0, fy_reg};
        xpos     = {1'b0, ow_st_reg} + {7'd0, fx_reg};
        y_off    = ypos - {7'd0, pad};
        x_off    = xpos - {7'd0, pad};
        in_image = (ypos >= {7'd0, pad}) && (y_off < {4'd0, h}) &&
                   (xpos >= {7'd0, pad}) && (x_off < {4'd0, w});
        row_term = {6'd0, y_off[4:0]} * {5'd0, w};
        addr_sum = {1'b0, c_base_reg} + {2'b00, row_term} + {8'd0, x_off[4:0]};
        rd_addr  = addr_sum[im2col_pkg::ADDR_W-1:0];

        last_fx  = ({1'b0, fx_reg} + 4'd1) == fw;
        last_fy  = ({1'b0, fy_reg} + 4'd1) == fh;
        last_col = ({1'b0, read_col_reg} + 9'd1) == cols_reg;
        last_row = (read_row_reg + 12'd1) == rows_reg;
        last_ow  = (ow_reg + 6'd1) == out_w_reg;
    end

    // ------------------------------------------------------------------
    // setup sequencer and counters
    assign div_go = div_rsp.done && !launch_reg;

    always_comb
    begin
        state_next    = state_reg;
        launch_next   = 1'b0;
        out_h_next    = out_h_reg;
        out_w_next    = out_w_reg;
        rows_next     = rows_reg;
        hw_next       = hw_reg;
        fhw_next      = fhw_reg;
        cols_next     = cols_reg;
        size_next     = size_reg;
        err_next      = err_reg;
        col_rem_next  = col_rem_reg;
        load_pos_next = load_pos_reg;
        read_row_next = read_row_reg;
        read_col_next = read_col_reg;
        oh_next       = oh_reg;
        ow_next       = ow_reg;
        c_next        = c_reg;
        fy_next       = fy_reg;
        fx_next       = fx_reg;
        oh_st_next    = oh_st_reg;
        ow_st_next    = ow_st_reg;
        c_base_next   = c_base_reg;

        div_req.start    = launch_reg;
        div_req.dividend = '0;
        div_req.divisor  = 7'd1;

        unique case (state_reg)
            ST_DIV_OH:
            begin
                div_req.dividend = {5'd0, extent_h};
                div_req.divisor  = {3'b000, st};
                if (div_go)
                begin
                    out_h_next  = div_rsp.quotient[5:0] + 6'd1;
                    state_next  = ST_DIV_OW;
                    launch_next = 1'b1;
                end
            end
            ST_DIV_OW:
            begin
                div_req.dividend = {5'd0, extent_w};
                div_req.divisor  = {3'b000, st};
                if (div_go)
                begin
                    out_w_next = div_rsp.quotient[5:0] + 6'd1;
                    state_next = ST_PROD1;
                end
            end
            ST_PROD1:
            begin
                rows_next  = {6'd0, out_h_reg} * {6'd0, out_w_reg};
                hw_next    = {5'd0, h} * {5'd0, w};
                fhw_next   = {3'b000, fh} * {3'b000, fw};
                err_next   = err_now;
                state_next = ST_PROD2;
            end
            ST_PROD2:
            begin
                cols_next  = {6'd0, ch} * {2'b00, fhw_reg};
                size_next  = {10'd0, ch} * {2'b00, hw_reg};
                state_next = ST_NORM;
            end
            ST_NORM:
            begin
                // restart any counter left beyond the new image or matrix size
                if (read_row_reg >= rows_reg)
                    read_row_next = '0;
                if ({1'b0, read_col_reg} >= cols_reg)
                    read_col_next = '0;
                if ({1'b0, load_pos_reg} >= size_reg)
                    load_pos_next = '0;
                state_next  = ST_DIV_ROW;
                launch_next = 1'b1;
            end
            ST_DIV_ROW:
            begin
                div_req.dividend = read_row_reg;
                div_req.divisor  = {1'b0, out_w_reg};
                if (div_go)
                begin
                    oh_next     = div_rsp.quotient[5:0];
                    ow_next     = div_rsp.remainder[5:0];
                    state_next  = ST_DIV_COL;
                    launch_next = 1'b1;
                end
            end
            ST_DIV_COL:
            begin
                div_req.dividend = {4'd0, read_col_reg};
                div_req.divisor  = fhw_reg;
                if (div_go)
                begin
                    c_next       = div_rsp.quotient[1:0];
                    col_rem_next = div_rsp.remainder[5:0];
                    state_next   = ST_DIV_REM;
                    launch_next  = 1'b1;
                end
            end
            ST_DIV_REM:
            begin
                div_req.dividend = {6'd0, col_rem_reg};
                div_req.divisor  = {3'b000, fw};
                if (div_go)
                begin
                    fy_next    = div_rsp.quotient[2:0];
                    fx_next    = div_rsp.remainder[2:0];
                    state_next = ST_PROD3;
                end
            end
            ST_PROD3:
            begin
                oh_st_next  = {3'b000, oh_reg} * {5'd0, st};
                ow_st_next  = {3'b000, ow_reg} * {5'd0, st};
                c_base_next = {10'd0, c_reg} * {1'b0, hw_reg};
                state_next  = ST_RUN;
            end
            ST_RUN:
            begin
                if (ld_req)
                begin
                    if (({1'b0, load_pos_reg} + 13'd1) == size_reg)
                        load_pos_next = '0;
                    else
                        load_pos_next = load_pos_reg + im2col_pkg::ADDR_W'(1);
                end

                if (rd_req)
                begin
                    if (err_reg)
                    begin
                        read_row_next = '0;
                        read_col_next = '0;
                        oh_next       = '0;
                        ow_next       = '0;
                        c_next        = '0;
                        fy_next       = '0;
                        fx_next       = '0;
                        oh_st_next    = '0;
                        ow_st_next    = '0;
                        c_base_next   = '0;
                    end
                    else if (last_col)
                    begin
                        read_col_next = '0;
                        c_next        = '0;
                        fy_next       = '0;
                        fx_next       = '0;
                        c_base_next   = '0;
                        if (last_row)
                        begin
                            read_row_next = '0;
                            oh_next       = '0;
                            ow_next       = '0;
                            oh_st_next    = '0;
                            ow_st_next    = '0;
                        end
                        else
                        begin
                            read_row_next = read_row_reg + 12'd1;
                            if (last_ow)
                            begin
                                ow_next    = '0;
                                ow_st_next = '0;
                                oh_next    = oh_reg + 6'd1;
                                oh_st_next = oh_st_reg + {5'd0, st};
                            end
                            else
                            begin
                                ow_next    = ow_reg + 6'd1;
                                ow_st_next = ow_st_reg + {5'd0, st};
                            end
                        end
                    end
                    else
                    begin
                        read_col_next = read_col_reg + 8'd1;
                        if (last_fx)
                        begin
                            fx_next = '0;
                            if (last_fy)
                            begin
                                fy_next     = '0;
                                c_next      = c_reg + 2'd1;
                                c_base_next = c_base_reg + {1'b0, hw_reg};
                            end
                            else
                            begin
                                fy_next = fy_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            fx_next = fx_reg + 3'd1;
                        end
                    end
                end
            end
            default:
            begin
                state_next  = ST_DIV_OH;
                launch_next = 1'b1;
            end
        endcase

        // any register write restarts setup
        if (cfg_valid)
        begin
            state_next  = ST_DIV_OH;
            launch_next = 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // pipeline valids
    always_comb
    begin
        s1_valid_next = rd_req || (s1_valid_reg && !out_free);
        if (out_free)
            out_valid_next = s1_valid_reg;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_DIV_OH;
            launch_reg        <= 1'b1;
            in_height_reg     <= 6'd28;
            in_width_reg      <= 6'd28;
            channels_reg      <= 3'd1;
            filter_height_reg <= 4'd3;
            filter_width_reg  <= 4'd3;
            stride_reg        <= 4'd1;
            padding_reg       <= 3'd0;
            load_pos_reg      <= '0;
            read_row_reg      <= '0;
            read_col_reg      <= '0;
            oh_reg            <= '0;
            ow_reg            <= '0;
            c_reg             <= '0;
            fy_reg            <= '0;
            fx_reg            <= '0;
            oh_st_reg         <= '0;
            ow_st_reg         <= '0;
            c_base_reg        <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            launch_reg        <= launch_next;
            in_height_reg     <= in_height_next;
            in_width_reg      <= in_width_next;
            channels_reg      <= channels_next;
            filter_height_reg <= filter_height_next;
            filter_width_reg  <= filter_width_next;
            stride_reg        <= stride_next;
            padding_reg       <= padding_next;
            load_pos_reg      <= load_pos_next;
            read_row_reg      <= read_row_next;
            read_col_reg      <= read_col_next;
            oh_reg            <= oh_next;
            ow_reg            <= ow_next;
            c_reg             <= c_next;
            fy_reg            <= fy_next;
            fx_reg            <= fx_next;
            oh_st_reg         <= oh_st_next;
            ow_st_reg         <= ow_st_next;
            c_base_reg        <= c_base_next;
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // setup results and item payloads
    always_ff @(posedge clk)
    begin
        out_h_reg   <= out_h_next;
        out_w_reg   <= out_w_next;
        rows_reg    <= rows_next;
        hw_reg      <= hw_next;
        fhw_reg     <= fhw_next;
        cols_reg    <= cols_next;
        size_reg    <= size_next;
        err_reg     <= err_next;
        col_rem_reg <= col_rem_next;

        if (rd_req)
        begin
            s1_row_reg <= err_reg ? 12'd0 : read_row_reg;
            s1_col_reg <= err_reg ? 8'd0 : read_col_reg;
            s1_pad_reg <= !err_reg && !in_image;
            s1_eor_reg <= err_reg || last_col;
            s1_eom_reg <= err_reg || (last_col && last_row);
            s1_err_reg <= err_reg;
        end

        if (out_free && s1_valid_reg)
        begin
            out_value_reg <= (s1_pad_reg || s1_err_reg) ? 32'd0 : rd_data_reg;
            out_row_reg   <= s1_row_reg;
            out_col_reg   <= s1_col_reg;
            out_pad_reg   <= s1_pad_reg;
            out_eor_reg   <= s1_eor_reg;
            out_eom_reg   <= s1_eom_reg;
            out_err_reg   <= s1_err_reg;
        end
    end

    // image store: one write port for loads, one registered read port for elements
    always_ff @(posedge clk)
    begin
        if (ld_req)
            store_mem[load_pos_reg] <= s_tdata;
        if (rd_req)
            rd_data_reg <= store_mem[rd_addr];
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_col_reg, out_row_reg, out_value_reg};
    assign m_tlast  = out_eor_reg;
    assign m_tuser  = {out_err_reg, out_eom_reg, out_pad_reg};

    // ------------------------------------------------------------------
    // checks

    a_counters_in_range: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !err_reg) |->
            (({1'b0, read_col_reg} < cols_reg) && (read_row_reg < rows_reg) &&
             ({1'b0, load_pos_reg} < size_reg))
    ) else $error("read or load counter out of range");

    a_column_split_matches: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !err_reg) |->
            ((read_col_reg == '0) == (c_reg == '0 && fy_reg == '0 && fx_reg == '0))
    ) else $error("column counter and its split disagree");

    a_window_offset_matches: assert property (
        @(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN && !err_reg) |->
            ((ow_st_reg == ({3'b000, ow_reg} * {5'd0, st})) &&
             (oh_st_reg == ({3'b000, oh_reg} * {5'd0, st})))
    ) else $error("window offset out of step with position");

    a_no_accept_when_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !m_tready) |-> !s_tready
    ) else $error("item accepted with both stages full");

endmodule

`default_nettype wire

FILE: tb/im2col_patch_extractor_unit_tb.sv
module im2col_patch_extractor_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import im2col_pkg::*;

    localparam bit KIND_LOAD   = 1'b0;
    localparam bit KIND_READ   = 1'b1;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic [31:0] value;
        logic [11:0] row_idx;
        logic [7:0]  col_idx;
        logic        is_padding;
        logic        end_of_row;
        logic        end_of_matrix;
        logic        config_error;
    } element_t;

    class patch_scoreboard;
        logic [5:0]  in_height, in_width;
        logic [2:0]  channels, padding;
        logic [3:0]  filter_h, filter_w, stride;
        int unsigned g_h, g_w, g_ch, g_fh, g_fw, g_st, g_pad;
        int unsigned g_size, g_out_w, g_rows, g_cols;
        bit          g_err;
        logic [31:0] image [STORE_DEPTH];
        bit          written [STORE_DEPTH];
        int unsigned load_pos, row_ptr, col_ptr;
        element_t    pending_elements [$];
        int          errors;

        function new();
            in_height = 6'd28;
            in_width  = 6'd28;
            channels  = 3'd1;
            filter_h  = 4'd3;
            filter_w  = 4'd3;
            stride    = 4'd1;
            padding   = 3'd0;
            load_pos  = 0;
            row_ptr   = 0;
            col_ptr   = 0;
            errors    = 0;
            foreach (written[i]) written[i] = 1'b0;
            derive();
        endfunction

        function int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
            if (v < lo) return lo;
            if (v > hi) return hi;
            return v;
        endfunction

        function void derive();
            g_h    = clip(in_height, 1, MAX_HEIGHT);
            g_w    = clip(in_width, 1, MAX_WIDTH);
            g_ch   = clip(channels, 1, MAX_CHANNELS);
            g_fh   = clip(filter_h, 1, MAX_FILTER);
            g_fw   = clip(filter_w, 1, MAX_FILTER);
            g_st   = clip(stride, 1, MAX_STRIDE);
            g_pad  = padding;
            g_size = g_ch * g_h * g_w;
            g_cols = g_ch * g_fh * g_fw;
            g_err  = (g_fh > g_h + 2 * g_pad) || (g_fw > g_w + 2 * g_pad);
            if (!g_err) begin
                g_out_w = (g_w + 2 * g_pad - g_fw) / g_st + 1;
                g_rows  = ((g_h + 2 * g_pad - g_fh) / g_st + 1) * g_out_w;
            end
        endfunction

        function void set_reg(cfg_reg_t r, logic [5:0] d);
            case (r)
                REG_IN_HEIGHT:     in_height = d;
                REG_IN_WIDTH:      in_width  = d;
                REG_CHANNELS:      channels  = d[2:0];
                REG_FILTER_HEIGHT: filter_h  = d[3:0];
                REG_FILTER_WIDTH:  filter_w  = d[3:0];
                REG_STRIDE:        stride    = d[3:0];
                REG_PADDING:       padding   = d[2:0];
                default: ;
            endcase
            derive();
        endfunction

        function bit image_covered();
            for (int i = 0; i < g_size; i++)
                if (!written[i % STORE_DEPTH]) return 1'b0;
            return 1'b1;
        endfunction

        // Work out the next matrix element without advancing the read counters.
        function void peek_element(output element_t e, output int unsigned addr,
                                   output int unsigned row, output int unsigned col);
            int unsigned oh, ow, c, rem, fy, fx;
            int          y, x;
            bit          in_img;
            e    = '0;
            addr = 0;
            row  = 0;
            col  = 0;
            if (g_err) begin
                e.end_of_row    = 1'b1;
                e.end_of_matrix = 1'b1;
                e.config_error  = 1'b1;
                return;
            end
            row = (row_ptr >= g_rows) ? 0 : row_ptr;
            col = (col_ptr >= g_cols) ? 0 : col_ptr;
            oh  = row / g_out_w;
            ow  = row % g_out_w;
            c   = col / (g_fh * g_fw);
            rem = col % (g_fh * g_fw);
            fy  = rem / g_fw;
            fx  = rem % g_fw;
            y   = int'(oh * g_st + fy) - int'(g_pad);
            x   = int'(ow * g_st + fx) - int'(g_pad);
            in_img = (y >= 0) && (y < int'(g_h)) && (x >= 0) && (x < int'(g_w));
            if (in_img) begin
                addr    = ((c * g_h + y) * g_w + x) % STORE_DEPTH;
                e.value = image[addr];
            end
            e.row_idx       = row[11:0];
            e.col_idx       = col[7:0];
            e.is_padding    = !in_img;
            e.end_of_row    = (col + 1 == g_cols);
            e.end_of_matrix = e.end_of_row && (row + 1 == g_rows);
        endfunction

        // A read may only touch store entries that have been loaded.
        function bit read_safe();
            element_t    e;
            int unsigned addr, row, col;
            peek_element(e, addr, row, col);
            return e.config_error || e.is_padding || written[addr];
        endfunction

        function void note_item(bit kind, logic [31:0] pixel);
            element_t    e;
            int unsigned addr, row, col;
            if (kind == KIND_LOAD) begin
                if (load_pos >= g_size) load_pos = 0;
                image[load_pos % STORE_DEPTH]   = pixel;
                written[load_pos % STORE_DEPTH] = 1'b1;
                load_pos++;
                if (load_pos >= g_size) load_pos = 0;
            end
            else begin
                peek_element(e, addr, row, col);
                pending_elements.push_back(e);
                if (e.config_error) begin
                    row_ptr = 0;
                    col_ptr = 0;
                end
                else if (e.end_of_row) begin
                    col_ptr = 0;
                    row_ptr = e.end_of_matrix ? 0 : row + 1;
                end
                else begin
                    row_ptr = row;
                    col_ptr = col + 1;
                end
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_element(logic [55:0] data, logic last, logic [2:0] user);
            element_t want;
            if (pending_elements.size() == 0) begin
                $display("%0t: unexpected item, expected none, actual value %0h row %0d col %0d",
                         $time, data[31:0], data[43:32], data[51:44]);
                errors++;
                return;
            end
            want = pending_elements.pop_front();
            compare_field("value", want.value, data[31:0]);
            compare_field("row_index", want.row_idx, data[43:32]);
            compare_field("column_index", want.col_idx, data[51:44]);
            compare_field("tdata fill", 0, data[55:52]);
            compare_field("is_padding", want.is_padding, user[0]);
            compare_field("end_of_row", want.end_of_row, last);
            compare_field("end_of_matrix", want.end_of_matrix, user[1]);
            compare_field("config_error", want.config_error, user[2]);
        endfunction

        function int pending();
            return pending_elements.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    cfg_reg_t    cfg_index;
    logic [5:0]  cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;
    logic        m_tlast;
    logic [2:0]  m_tuser;

    patch_scoreboard sb;
    logic [5:0]      cfg_vals [7];
    bit              steady;
    int              items_sent;
    int              cycles;

    im2col_patch_extractor_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Output side: stall at random except during steady stretches.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            m_tready <= steady || ($urandom_range(99) >= 31);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_element(m_tdata, m_tlast, m_tuser);
    end

    task automatic send_item(input bit kind, input logic [31:0] pixel);
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= pixel;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_item(kind, pixel);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic push_item(input bit kind_in);
        bit          kind;
        logic [31:0] pixel;
        kind = kind_in;
        // swap in a load when the read would hit an entry not loaded yet
        if (kind == KIND_READ && !sb.read_safe()) kind = KIND_LOAD;
        case ($urandom_range(15))
            0:       pixel = '0;
            1:       pixel = '1;
            default: pixel = $urandom;
        endcase
        if (!steady && $urandom_range(99) < 31) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge clk);
        end
        send_item(kind, pixel);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_config();
        cfg_reg_t r;
        r = r.first();
        repeat (r.num())
        begin
            cfg_valid <= 1'b1;
            cfg_index <= r;
            cfg_data  <= cfg_vals[r];
            @(posedge clk);
            while (!cfg_ready) @(posedge clk);
            sb.set_reg(r, cfg_vals[r]);
            @(negedge clk);
            r = r.next();
        end
        cfg_valid <= 1'b0;
    endtask

    // Drain results, then let the last load retire before touching registers.
    task automatic settle_and_configure();
        wait_drained();
        repeat (6) @(negedge clk);
        write_config();
    endtask

    task automatic pick_config(input bit extreme);
        int unsigned big, tiny;
        if (!extreme) begin
            cfg_vals[REG_IN_HEIGHT]     = $urandom_range(1, 6);
            cfg_vals[REG_IN_WIDTH]      = $urandom_range(1, 6);
            cfg_vals[REG_CHANNELS]      = $urandom_range(1, 4);
            cfg_vals[REG_FILTER_HEIGHT] = $urandom_range(1, 4);
            cfg_vals[REG_FILTER_WIDTH]  = $urandom_range(1, 4);
            cfg_vals[REG_STRIDE]        = $urandom_range(1, 3);
            cfg_vals[REG_PADDING]       = $urandom_range(0, 2);
        end
        else begin
            // keep one image side long and the other short so the load stays cheap
            big  = $urandom_range(1) ? 32 : $urandom_range(33, 63);
            tiny = $urandom_range(0, 2);
            cfg_vals[REG_IN_HEIGHT] = $urandom_range(1) ? big : tiny;
            cfg_vals[REG_IN_WIDTH]  = (cfg_vals[REG_IN_HEIGHT] == big) ? tiny : big;
            case ($urandom_range(3))
                0:       cfg_vals[REG_CHANNELS] = 0;
                1:       cfg_vals[REG_CHANNELS] = MAX_CHANNELS;
                2:       cfg_vals[REG_CHANNELS] = $urandom_range(5, 7);
                default: cfg_vals[REG_CHANNELS] = 1;
            endcase
            case ($urandom_range(3))
                0:       cfg_vals[REG_FILTER_HEIGHT] = 0;
                1:       cfg_vals[REG_FILTER_HEIGHT] = MAX_FILTER;
                2:       cfg_vals[REG_FILTER_HEIGHT] = $urandom_range(9, 15);
                default: cfg_vals[REG_FILTER_HEIGHT] = $urandom_range(1, 3);
            endcase
            case ($urandom_range(3))
                0:       cfg_vals[REG_FILTER_WIDTH] = 0;
                1:       cfg_vals[REG_FILTER_WIDTH] = MAX_FILTER;
                2:       cfg_vals[REG_FILTER_WIDTH] = $urandom_range(9, 15);
                default: cfg_vals[REG_FILTER_WIDTH] = $urandom_range(1, 3);
            endcase
            case ($urandom_range(3))
                0:       cfg_vals[REG_STRIDE] = 0;
                1:       cfg_vals[REG_STRIDE] = MAX_STRIDE;
                2:       cfg_vals[REG_STRIDE] = $urandom_range(9, 15);
                default: cfg_vals[REG_STRIDE] = 1;
            endcase
            case ($urandom_range(2))
                0:       cfg_vals[REG_PADDING] = 0;
                1:       cfg_vals[REG_PADDING] = 7;
                default: cfg_vals[REG_PADDING] = $urandom_range(1, 6);
            endcase
        end
        // junk above the register width must be dropped
        if ($urandom_range(3) == 0) cfg_vals[REG_CHANNELS][5:3]      = $urandom_range(7);
        if ($urandom_range(3) == 0) cfg_vals[REG_FILTER_HEIGHT][5:4] = $urandom_range(3);
        if ($urandom_range(3) == 0) cfg_vals[REG_FILTER_WIDTH][5:4]  = $urandom_range(3);
        if ($urandom_range(3) == 0) cfg_vals[REG_STRIDE][5:4]        = $urandom_range(3);
        if ($urandom_range(3) == 0) cfg_vals[REG_PADDING][5:3]       = $urandom_range(7);
    endtask

    task automatic run_phase(input int n_reads, input bit drain_mid);
        while (!sb.image_covered())
            push_item(($urandom_range(9) == 0) ? KIND_READ : KIND_LOAD);
        for (int i = 0; i < n_reads; i++)
        begin
            if (drain_mid && i == n_reads / 2) wait_drained();
            push_item(($urandom_range(9) == 0) ? KIND_LOAD : KIND_READ);
        end
    endtask

    initial
    begin
        sb         = new();
        steady     = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_valid  = 1'b0;
        cfg_index  = REG_IN_HEIGHT;
        cfg_data   = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = KIND_LOAD;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Filter larger than the padded image: reads flag the error, loads still land.
        cfg_vals[REG_IN_HEIGHT]     = 1;
        cfg_vals[REG_IN_WIDTH]      = 1;
        cfg_vals[REG_CHANNELS]      = 1;
        cfg_vals[REG_FILTER_HEIGHT] = 3;
        cfg_vals[REG_FILTER_WIDTH]  = 3;
        cfg_vals[REG_STRIDE]        = 1;
        cfg_vals[REG_PADDING]       = 0;
        settle_and_configure();
        send_item(KIND_READ, 32'h0);
        send_item(KIND_READ, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, 32'h0);
        send_item(KIND_LOAD, 32'hFFFF_FFFF);

        // 2x2 image, 3x3 window, stride 2, border 1: one row of nine, mostly border.
        cfg_vals[REG_IN_HEIGHT]     = 2;
        cfg_vals[REG_IN_WIDTH]      = 2;
        cfg_vals[REG_STRIDE]        = 2;
        cfg_vals[REG_PADDING]       = 1;
        settle_and_configure();
        send_item(KIND_LOAD, 32'h0);
        send_item(KIND_LOAD, 32'hFFFF_FFFF);
        send_item(KIND_LOAD, 32'hA5A5_A5A5);
        send_item(KIND_LOAD, 32'h5A5A_5A5A);
        repeat (11) send_item(KIND_READ, 32'h0);

        for (int p = 0; items_sent < 1700 && p < 60; p++)
        begin
            pick_config(p % 3 == 1);
            settle_and_configure();
            steady = (p % 5 == 2);
            run_phase($urandom_range(40, 120), p % 4 == 0);
        end

        wait_drained();
        repeat (10) @(posedge clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: sim.f
src/im2col_pkg.sv
src/im2col_div.sv
src/im2col_patch_extractor_unit.sv
tb/im2col_patch_extractor_unit_tb.sv
